### rtl/core/hpack_huffman_decoder_core_assert.svh
// Assertion macros used by the decoder core RTL.
`ifndef HPACK_HUFFMAN_DECODER_CORE_ASSERT_SVH
`define HPACK_HUFFMAN_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define HPD_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define HPD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/hpd_pkg.sv
package hpd_pkg;

  localparam int MaxLen = 30;
  localparam int AccWidth = 37;

  // Result status codes.
  localparam logic [2:0] StsOk      = 3'd0;
  localparam logic [2:0] StsFull    = 3'd1;
  localparam logic [2:0] StsPad     = 3'd2;
  localparam logic [2:0] StsBadPad  = 3'd3;
  localparam logic [2:0] StsEmpty   = 3'd4;

  // Code length of every symbol of the fixed code.
  localparam logic [4:0] CodeLen [256] = '{
    5'd13, 5'd23, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28,
    5'd28, 5'd24, 5'd30, 5'd28, 5'd28, 5'd30, 5'd28, 5'd28,
    5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd30, 5'd28,
    5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28,
    5'd6, 5'd10, 5'd10, 5'd12, 5'd13, 5'd6, 5'd8, 5'd11,
    5'd10, 5'd10, 5'd8, 5'd11, 5'd8, 5'd6, 5'd6, 5'd6,
    5'd5, 5'd5, 5'd5, 5'd6, 5'd6, 5'd6, 5'd6, 5'd6,
    5'd6, 5'd6, 5'd7, 5'd8, 5'd15, 5'd6, 5'd12, 5'd10,
    5'd13, 5'd6, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7,
    5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7,
    5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7,
    5'd8, 5'd7, 5'd8, 5'd13, 5'd19, 5'd13, 5'd14, 5'd6,
    5'd15, 5'd5, 5'd6, 5'd5, 5'd6, 5'd5, 5'd6, 5'd6,
    5'd6, 5'd5, 5'd7, 5'd7, 5'd6, 5'd6, 5'd6, 5'd5,
    5'd6, 5'd7, 5'd6, 5'd5, 5'd5, 5'd6, 5'd7, 5'd7,
    5'd7, 5'd7, 5'd7, 5'd15, 5'd11, 5'd14, 5'd13, 5'd28,
    5'd20, 5'd22, 5'd20, 5'd20, 5'd22, 5'd22, 5'd22, 5'd23,
    5'd22, 5'd23, 5'd23, 5'd23, 5'd23, 5'd23, 5'd24, 5'd23,
    5'd24, 5'd24, 5'd22, 5'd23, 5'd24, 5'd23, 5'd23, 5'd23,
    5'd23, 5'd21, 5'd22, 5'd23, 5'd22, 5'd23, 5'd23, 5'd24,
    5'd22, 5'd21, 5'd20, 5'd22, 5'd22, 5'd23, 5'd23, 5'd21,
    5'd23, 5'd22, 5'd22, 5'd24, 5'd21, 5'd22, 5'd23, 5'd23,
    5'd21, 5'd21, 5'd22, 5'd21, 5'd23, 5'd22, 5'd23, 5'd23,
    5'd20, 5'd22, 5'd22, 5'd22, 5'd23, 5'd22, 5'd22, 5'd23,
    5'd26, 5'd26, 5'd20, 5'd19, 5'd22, 5'd23, 5'd22, 5'd25,
    5'd26, 5'd26, 5'd26, 5'd27, 5'd27, 5'd26, 5'd24, 5'd25,
    5'd19, 5'd21, 5'd26, 5'd27, 5'd27, 5'd26, 5'd27, 5'd24,
    5'd21, 5'd21, 5'd26, 5'd26, 5'd28, 5'd27, 5'd27, 5'd27,
    5'd20, 5'd24, 5'd20, 5'd21, 5'd22, 5'd21, 5'd21, 5'd23,
    5'd22, 5'd22, 5'd25, 5'd25, 5'd24, 5'd24, 5'd26, 5'd23,
    5'd26, 5'd27, 5'd26, 5'd26, 5'd27, 5'd27, 5'd27, 5'd27,
    5'd27, 5'd28, 5'd27, 5'd27, 5'd27, 5'd27, 5'd27, 5'd26
  };

  typedef logic [31:0] word_tab_t [MaxLen+1];
  typedef logic [7:0] sym_tab_t [256];

  // Number of codes of each length.
  function automatic word_tab_t calc_count();
    word_tab_t res;
    int n;
    int s;
    for (n = 0; n <= MaxLen; n++) begin
      res[n] = '0;
    end
    for (s = 0; s < 256; s++) begin
      res[CodeLen[s]] = res[CodeLen[s]] + 32'd1;
    end
    return res;
  endfunction

  // First canonical code of each length.
  function automatic word_tab_t calc_first(word_tab_t cnt);
    word_tab_t res;
    logic [31:0] first;
    int n;
    first = '0;
    res[0] = '0;
    for (n = 1; n <= MaxLen; n++) begin
      res[n] = first;
      first = (first + cnt[n]) << 1;
    end
    return res;
  endfunction

  // Index of the first symbol of each length in the sorted table.
  function automatic word_tab_t calc_base(word_tab_t cnt);
    word_tab_t res;
    logic [31:0] acc;
    int n;
    acc = '0;
    for (n = 0; n <= MaxLen; n++) begin
      res[n] = acc;
      acc = acc + cnt[n];
    end
    return res;
  endfunction

  // Symbols ordered by code length, then by value.
  function automatic sym_tab_t calc_sorted();
    sym_tab_t res;
    int idx;
    int n;
    int s;
    idx = 0;
    for (n = 1; n <= MaxLen; n++) begin
      for (s = 0; s < 256; s++) begin
        if (int'(CodeLen[s]) == n) begin
          res[idx] = 8'(s);
          idx = idx + 1;
        end
      end
    end
    return res;
  endfunction

  localparam word_tab_t CodeCount = calc_count();
  localparam word_tab_t CodeFirst = calc_first(CodeCount);
  localparam word_tab_t CodeBase  = calc_base(CodeCount);
  localparam sym_tab_t  SymSorted = calc_sorted();

  // Per-string state held in the state memory.
  typedef struct packed {
    logic [AccWidth-1:0] acc;
    logic [5:0]          cnt;
    logic [15:0]         dec;
    logic [2:0]          err;
  } hpd_state_t;

  // Result of the code length search.
  typedef struct packed {
    logic       found;
    logic [4:0] len;
  } hpd_match_t;

endpackage

### rtl/core/hpd_if.sv
// Input channel: one coded byte per beat.
interface hpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] coded_byte;
  logic       last_byte;

  modport source (output valid, output coded_byte, output last_byte, input ready);
  modport sink (input valid, input coded_byte, input last_byte, output ready);
endinterface

// Output channel: one symbol or end result per beat.
interface hpd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  symbol;
  logic        is_symbol;
  logic        end_of_string;
  logic [2:0]  status;
  logic [15:0] symbol_count;

  modport source (output valid, output symbol, output is_symbol, output end_of_string,
                  output status, output symbol_count, input ready);
  modport sink (input valid, input symbol, input is_symbol, input end_of_string,
                input status, input symbol_count, output ready);
endinterface

### rtl/core/hpd_ram.sv
module hpd_ram #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  generate
    if (Depth > 1) begin : g_multi
      // Write port and registered read port.
      always_ff @(posedge clk_i) begin
        if (we_i) begin
          mem_q[waddr_i] <= wdata_i;
        end
        rdata_q <= mem_q[raddr_i];
      end
    end else begin : g_single
      // A single entry needs no address decode.
      always_ff @(posedge clk_i) begin
        if (we_i && (waddr_i == raddr_i || !we_i || we_i)) begin
          mem_q[0] <= wdata_i;
        end
        rdata_q <= mem_q[0];
      end
    end
  endgenerate

  assign rdata_o = rdata_q;

endmodule

### rtl/core/hpd_search.sv
module hpd_search import hpd_pkg::*; (
  input  logic [AccWidth-1:0] acc_i,
  input  logic [5:0]          cnt_i,
  input  logic [4:0]          len_i,
  output hpd_match_t          match_o,
  output logic [7:0]          symbol_o
);

  logic [AccWidth-1:0] aligned;
  logic [MaxLen-1:0]   win;
  logic [MaxLen-1:0]   code_v;
  logic [31:0]         sym_idx;

  // Left-align the valid bits so that code prefixes start at the top.
  always_comb begin
    aligned = acc_i << (6'(AccWidth) - cnt_i);
    win     = aligned[AccWidth-1 -: MaxLen];
  end

  // Test every code length in parallel and keep the shortest hit.
  always_comb begin
    logic [MaxLen-1:0] v;
    logic [MaxLen-1:0] diff;
    match_o = '0;
    for (int n = MaxLen; n >= 1; n--) begin
      v    = win >> (MaxLen - n);
      diff = v - MaxLen'(CodeFirst[n]);
      if (6'(n) <= cnt_i && v >= MaxLen'(CodeFirst[n]) &&
          diff < MaxLen'(CodeCount[n])) begin
        match_o.found = 1'b1;
        match_o.len   = 5'(n);
      end
    end
  end

  // Map the code of the found length to its symbol.
  always_comb begin
    code_v   = win >> (5'(MaxLen) - len_i);
    sym_idx  = CodeBase[len_i] + {2'b00, code_v} - CodeFirst[len_i];
    symbol_o = SymSorted[sym_idx[7:0]];
  end

endmodule

### rtl/core/hpack_huffman_decoder_core.sv
// HPACK Huffman string decoder for the fixed code of RFC 7541. Bytes of one coded
// string arrive on in_i, one per beat, with last_byte on the final byte; decoded
// octets leave on out_o as soon as each code completes, and the final byte adds an
// end beat with status and symbol count. Per-string state lives in a one-entry
// state memory with a registered read. A byte that completes no symbol passes
// through accept, memory read, length search, leftover check and write-back
// before the next input beat is taken; each symbol it completes adds a symbol
// lookup with output load and a new length search, and output stalls hold the
// load. A byte completes at most two symbols; a byte of a string that already
// holds an error goes from the memory read straight to write-back.
// output_capacity may only be written while no string byte is in flight.
`include "hpack_huffman_decoder_core_assert.svh"

module hpack_huffman_decoder_core import hpd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  hpd_in_if.sink      in_i,
  hpd_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam logic [2:0] SIdle   = 3'd0;
  localparam logic [2:0] SLoad   = 3'd1;
  localparam logic [2:0] SSearch = 3'd2;
  localparam logic [2:0] SEmit   = 3'd3;
  localparam logic [2:0] SCheck  = 3'd4;
  localparam logic [2:0] SFinish = 3'd5;

  logic [2:0]          state_q, state_d;
  logic [7:0]          byte_q;
  logic                last_q;
  logic [AccWidth-1:0] acc_q, acc_d;
  logic [5:0]          cnt_q, cnt_d;
  logic [15:0]         dec_q, dec_d;
  logic [2:0]          err_q, err_d;
  logic [4:0]          len_q, len_d;
  logic [15:0]         cap_q;
  logic                mem_valid_q;

  logic                out_valid_q;
  logic [7:0]          out_sym_q;
  logic                out_is_sym_q;
  logic                out_eos_q;
  logic [2:0]          out_sts_q;
  logic [15:0]         out_cnt_q;

  logic                out_free;
  logic                out_load;
  logic [7:0]          load_sym;
  logic                load_is_sym;
  logic [2:0]          load_sts;
  logic [15:0]         load_cnt;

  hpd_state_t          ram_rdata;
  hpd_state_t          ram_wdata;
  hpd_state_t          rd_state;
  logic                ram_we;
  hpd_match_t          match;
  logic [7:0]          symbol;
  logic [2:0]          end_status;
  logic [6:0]          pad_mask;
  logic [AccWidth-1:0] keep_mask;

  // Per-string state memory.
  hpd_ram #(
    .Width($bits(hpd_state_t)),
    .Depth(1)
  ) u_state_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(1'b0),
    .wdata_i(ram_wdata),
    .raddr_i(1'b0),
    .rdata_o(ram_rdata)
  );

  // Canonical code search and symbol lookup.
  hpd_search u_search (
    .acc_i   (acc_q),
    .cnt_i   (cnt_q),
    .len_i   (len_q),
    .match_o (match),
    .symbol_o(symbol)
  );

  assign in_i.ready = (state_q == SIdle);
  assign out_free   = !out_valid_q || out_o.ready;
  assign rd_state   = mem_valid_q ? ram_rdata : '0;

  // End-of-string status, first check that applies wins.
  always_comb begin
    pad_mask = 7'((8'd1 << cnt_q[2:0]) - 8'd1);
    if (err_q != StsOk) begin
      end_status = err_q;
    end else if (cnt_q > 6'd7) begin
      end_status = StsPad;
    end else if ((acc_q[6:0] & pad_mask) != pad_mask) begin
      end_status = StsBadPad;
    end else if (dec_q == 16'd0) begin
      end_status = StsEmpty;
    end else begin
      end_status = StsOk;
    end
  end

  // Sequencer: read state, decode symbols one at a time, write state back.
  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    dec_d       = dec_q;
    err_d       = err_q;
    len_d       = len_q;
    ram_we      = 1'b0;
    ram_wdata   = '{acc: acc_q, cnt: cnt_q, dec: dec_q, err: err_q};
    out_load    = 1'b0;
    load_sym    = 8'd0;
    load_is_sym = 1'b0;
    load_sts    = StsOk;
    load_cnt    = 16'd0;
    keep_mask   = '0;
    case (state_q)
      SIdle: begin
        if (in_i.valid) begin
          state_d = SLoad;
        end
      end
      SLoad: begin
        acc_d = rd_state.acc;
        cnt_d = rd_state.cnt;
        dec_d = rd_state.dec;
        err_d = rd_state.err;
        if (rd_state.err == StsOk) begin
          acc_d   = {rd_state.acc[AccWidth-9:0], byte_q};
          cnt_d   = rd_state.cnt + 6'd8;
          state_d = SSearch;
        end else begin
          state_d = SFinish;
        end
      end
      SSearch: begin
        if (match.found) begin
          len_d   = match.len;
          state_d = SEmit;
        end else begin
          state_d = SCheck;
        end
      end
      SEmit: begin
        if (({1'b0, dec_q} + 17'd1) >= {1'b0, cap_q}) begin
          err_d   = StsFull;
          state_d = SFinish;
        end else if (out_free) begin
          dec_d       = dec_q + 16'd1;
          cnt_d       = cnt_q - {1'b0, len_q};
          keep_mask   = ~({AccWidth{1'b1}} << cnt_d);
          acc_d       = acc_q & keep_mask;
          out_load    = 1'b1;
          load_sym    = symbol;
          load_is_sym = 1'b1;
          state_d     = SSearch;
        end
      end
      SCheck: begin
        if (cnt_q >= 6'(MaxLen)) begin
          err_d = StsPad;
          acc_d = '0;
          cnt_d = 6'd0;
        end
        state_d = SFinish;
      end
      SFinish: begin
        if (!last_q) begin
          ram_we  = 1'b1;
          state_d = SIdle;
        end else if (out_free) begin
          ram_we    = 1'b1;
          ram_wdata = '0;
          out_load  = 1'b1;
          load_sts  = end_status;
          load_cnt  = dec_q;
          state_d   = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      cap_q       <= 16'd4096;
      mem_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (ram_we) begin
        mem_valid_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working and output payload registers.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q <= in_i.coded_byte;
      last_q <= in_i.last_byte;
    end
    acc_q <= acc_d;
    cnt_q <= cnt_d;
    dec_q <= dec_d;
    err_q <= err_d;
    len_q <= len_d;
    if (out_load) begin
      out_sym_q    <= load_sym;
      out_is_sym_q <= load_is_sym;
      out_eos_q    <= !load_is_sym;
      out_sts_q    <= load_sts;
      out_cnt_q    <= load_cnt;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.symbol        = out_sym_q;
  assign out_o.is_symbol     = out_is_sym_q;
  assign out_o.end_of_string = out_eos_q;
  assign out_o.status        = out_sts_q;
  assign out_o.symbol_count  = out_cnt_q;

  `HPD_ASSERT_IMP(a_search_cnt_range, state_q == SSearch, cnt_q <= 6'(AccWidth),
                  "bit count out of range during search")
  `HPD_ASSERT_NEXT(a_emit_shows_beat, state_q == SEmit && out_load, out_o.valid,
                   "emitted symbol not presented")
  `HPD_ASSERT_IMP(a_end_only_last, out_load && !load_is_sym, last_q,
                  "end result without last byte")
  `HPD_ASSERT_NEXT(a_finish_to_idle, state_q == SFinish && ram_we, state_q == SIdle,
                   "state write-back did not return to idle")

endmodule

### sim/hpack_huffman_decoder_core_tb.sv
module hpack_huffman_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hpd_pkg::*;

  typedef struct {
    logic [7:0] coded_byte;
    logic       last_byte;
  } coded_beat_t;

  typedef struct {
    logic [7:0]  symbol;
    logic        is_symbol;
    logic        end_of_string;
    logic [2:0]  status;
    logic [15:0] symbol_count;
  } decoded_beat_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [15:0] cfg_wdata_i;

  hpd_in_if  in_ch ();
  hpd_out_if out_ch ();

  hpack_huffman_decoder_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Canonical code tables built from the code lengths.
  int unsigned len_total [MaxLen+1];
  int unsigned len_first [MaxLen+1];
  int unsigned len_start [MaxLen+1];
  logic [7:0]  by_length [256];
  int unsigned sym_code  [256];

  // Decoder state as the design should hold it.
  logic [36:0] acc_bits;
  int unsigned acc_len;
  int unsigned sym_total;
  logic [2:0]  sticky_err;
  int unsigned capacity;

  coded_beat_t   pending_bytes [$];
  decoded_beat_t expected_out [$];
  bit            stream_bits [$];

  int  mismatches;
  int  idle_cycles;
  bit  quiet;
  bit  in_fire;
  int  send_gap;
  int  recv_gap;

  always #5 clk_i = ~clk_i;

  function automatic void build_code();
    int unsigned first;
    int unsigned idx;
    int unsigned rank;
    first = 0;
    idx = 0;
    for (int n = 0; n <= MaxLen; n++) begin
      len_total[n] = 0;
    end
    for (int s = 0; s < 256; s++) begin
      len_total[CodeLen[s]]++;
    end
    for (int n = 1; n <= MaxLen; n++) begin
      len_first[n] = first;
      len_start[n] = idx;
      rank = 0;
      for (int s = 0; s < 256; s++) begin
        if (CodeLen[s] == n) begin
          by_length[idx] = 8'(s);
          sym_code[s] = first + rank;
          idx++;
          rank++;
        end
      end
      first = (first + len_total[n]) << 1;
    end
  endfunction

  function automatic void clear_stream();
    acc_bits = '0;
    acc_len = 0;
    sym_total = 0;
    sticky_err = StsOk;
  endfunction

  // Decode one accepted byte and queue the beats it should produce.
  function automatic void decode_byte(logic [7:0] cb, logic lb);
    decoded_beat_t r;
    int unsigned v;
    int unsigned hit_len;
    int hit_sym;
    int emitted;
    logic [36:0] ones;
    emitted = 0;
    if (sticky_err == StsOk) begin
      acc_bits = {acc_bits[28:0], cb};
      acc_len += 8;
      forever begin
        hit_sym = -1;
        hit_len = 0;
        for (int n = 1; n <= MaxLen && hit_sym < 0; n++) begin
          if (n <= acc_len) begin
            v = 32'(acc_bits >> (acc_len - n)) & ((32'd1 << n) - 1);
            if (v >= len_first[n] && v - len_first[n] < len_total[n]) begin
              hit_sym = int'(by_length[len_start[n] + v - len_first[n]]);
              hit_len = n;
            end
          end
        end
        if (hit_sym < 0) break;
        if (sym_total + 1 >= capacity) begin
          sticky_err = StsFull;
          break;
        end
        sym_total++;
        acc_len -= hit_len;
        acc_bits &= (37'd1 << acc_len) - 1;
        if (emitted < 2) begin
          r = '{8'(hit_sym), 1'b1, 1'b0, StsOk, 16'd0};
          expected_out.push_back(r);
          emitted++;
        end
      end
      if (sticky_err == StsOk && acc_len >= MaxLen) begin
        sticky_err = StsPad;
        acc_bits = '0;
        acc_len = 0;
      end
    end
    if (lb) begin
      ones = (37'd1 << acc_len) - 1;
      r = '{8'd0, 1'b0, 1'b1, StsOk, 16'(sym_total)};
      if (sticky_err != StsOk) r.status = sticky_err;
      else if (acc_len > 7) r.status = StsPad;
      else if (acc_len > 0 && (acc_bits & ones) != ones) r.status = StsBadPad;
      else if (sym_total == 0) r.status = StsEmpty;
      expected_out.push_back(r);
      clear_stream();
    end
  endfunction

  function automatic void put_bits(int unsigned val, int unsigned n);
    for (int i = n - 1; i >= 0; i--) begin
      stream_bits.push_back(val[i]);
    end
  endfunction

  // Flush the bit stream into bytes; the last byte carries the end flag.
  function automatic void flush_stream(bit pad_ok);
    coded_beat_t b;
    int unsigned pad;
    pad = (8 - stream_bits.size() % 8) % 8;
    for (int i = 0; i < pad; i++) begin
      stream_bits.push_back(1'b1);
    end
    if (!pad_ok && pad > 0) begin
      stream_bits[stream_bits.size() - 1 - $urandom_range(0, pad - 1)] = 1'b0;
    end
    if (stream_bits.size() == 0) begin
      put_bits(32'hff, 8);
    end
    while (stream_bits.size() > 0) begin
      for (int i = 0; i < 8; i++) begin
        b.coded_byte[7 - i] = stream_bits.pop_front();
      end
      b.last_byte = (stream_bits.size() == 0);
      pending_bytes.push_back(b);
    end
  endfunction

  function automatic int pick_symbol();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 255);
    return $urandom_range(32, 126);
  endfunction

  // One well-formed string with an optional flaw.
  // flaw: 0 none, 1 bad padding, 2 extra ones byte, 3 EOS inside, 4 raw noise.
  function automatic void add_string(int nsym, int flaw);
    int s;
    coded_beat_t b;
    if (flaw == 4) begin
      for (int i = 0; i < nsym + 1; i++) begin
        b.coded_byte = 8'($urandom);
        b.last_byte = (i == nsym);
        pending_bytes.push_back(b);
      end
      return;
    end
    for (int i = 0; i < nsym; i++) begin
      s = pick_symbol();
      put_bits(sym_code[s], 32'(CodeLen[s]));
      if (flaw == 3 && i == nsym / 2) put_bits(32'h3fffffff, MaxLen);
    end
    if (flaw == 2) put_bits(32'hff, 8);
    flush_stream(flaw != 1);
  endfunction

  function automatic void add_symbols(int first_sym, int last_sym);
    for (int s = first_sym; s <= last_sym; s++) begin
      put_bits(sym_code[s], 32'(CodeLen[s]));
    end
    flush_stream(1'b1);
  endfunction

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || expected_out.size() != 0 || in_ch.valid) begin
      @(posedge clk_i);
    end
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_capacity(logic [15:0] cap);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = cap;
    capacity = 32'(cap);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic random_strings(int nbytes);
    int start;
    int r;
    start = pending_bytes.size();
    while (pending_bytes.size() - start < nbytes) begin
      r = $urandom_range(0, 9);
      if (r < 6) add_string($urandom_range(0, 8), 0);
      else if (r == 6) add_string($urandom_range(1, 6), 1);
      else if (r == 7) add_string($urandom_range(0, 4), 2);
      else if (r == 8) add_string($urandom_range(1, 5), 3);
      else add_string($urandom_range(0, 4), 4);
    end
  endtask

  // Stimulus phases, each started only once the decoder has drained.
  initial begin
    coded_beat_t b;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    quiet = 1'b0;
    build_code();
    clear_stream();
    capacity = 4096;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed cases at the reset capacity.
    b = '{8'h00, 1'b1}; pending_bytes.push_back(b);
    b = '{8'hff, 1'b1}; pending_bytes.push_back(b);
    add_symbols(0, 0);
    add_symbols(255, 255);
    add_symbols(10, 10);
    add_symbols(48, 50);
    add_string(4, 1);
    add_string(3, 3);
    add_string(2, 2);
    add_symbols(97, 101);
    wait_drained();

    set_capacity(16'd1);
    add_string(2, 0);
    add_string(3, 3);
    random_strings(30);
    wait_drained();

    set_capacity(16'd3);
    random_strings(80);
    wait_drained();

    set_capacity(16'hffff);
    random_strings(150);
    wait_drained();

    set_capacity(16'd4096);
    random_strings(120);
    wait_drained();

    // Last part runs with no idling on either side.
    quiet = 1'b1;
    set_capacity(16'd7);
    random_strings(100);
    wait_drained();

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Input driver.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.coded_byte <= '0;
      in_ch.last_byte <= 1'b0;
      send_gap = 0;
    end else if (!in_ch.valid || in_fire) begin
      if (!quiet && send_gap == 0 && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 5);
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        in_ch.coded_byte <= pending_bytes[0].coded_byte;
        in_ch.last_byte <= pending_bytes[0].last_byte;
        void'(pending_bytes.pop_front());
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Output ready with random stalls.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (!quiet && recv_gap == 0 && $urandom_range(0, 5) == 0) recv_gap = $urandom_range(1, 5);
      if (recv_gap > 0) begin
        recv_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor: predict on every input beat, check every output beat.
  always @(posedge clk_i) begin
    decoded_beat_t want;
    in_fire <= rst_ni && in_ch.valid && in_ch.ready;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        decode_byte(in_ch.coded_byte, in_ch.last_byte);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_out.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected beat: sym=%0d is_sym=%0d eos=%0d st=%0d cnt=%0d",
                     out_ch.symbol, out_ch.is_symbol, out_ch.end_of_string,
                     out_ch.status, out_ch.symbol_count);
          end
        end else begin
          want = expected_out.pop_front();
          if (out_ch.symbol !== want.symbol || out_ch.is_symbol !== want.is_symbol ||
              out_ch.end_of_string !== want.end_of_string ||
              out_ch.status !== want.status || out_ch.symbol_count !== want.symbol_count) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: exp sym=%0d is_sym=%0d eos=%0d st=%0d cnt=%0d",
                       want.symbol, want.is_symbol, want.end_of_string,
                       want.status, want.symbol_count);
              $display("          got sym=%0d is_sym=%0d eos=%0d st=%0d cnt=%0d",
                       out_ch.symbol, out_ch.is_symbol, out_ch.end_of_string,
                       out_ch.status, out_ch.symbol_count);
            end
          end
        end
      end
    end
  end

  // Watchdog on cycles with no beat on either side.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= 3000) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/hpd_pkg.sv
rtl/core/hpd_if.sv
rtl/core/hpd_ram.sv
rtl/core/hpd_search.sv
rtl/core/hpack_huffman_decoder_core.sv
sim/hpack_huffman_decoder_core_tb.sv
